// ===== rtl/itoa_pkg.sv =====
// Shared types and constants for the signed integer to decimal ASCII converter.
`timescale 1ns / 1ps

package itoa_pkg;

	localparam int VALUE_W    = 32;
	localparam int CHAR_W     = 8;
	localparam int NUM_DIGITS = 10;
	localparam int BCD_W      = 4 * NUM_DIGITS;

	localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;
	localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_TRIM,
		ST_SIGN,
		ST_DIGIT
	} state_t;

endpackage

// ===== rtl/signed_int_to_decimal_ascii.sv =====
// Converts a signed 32-bit integer to its decimal ASCII text, one character per output transfer.
`timescale 1ns / 1ps
// A taken value runs through bit-serial double dabble, then leading zeros are dropped,
// then the sign (for a negative value) and the digits are sent, most significant first.
// One value at a time: a new value is taken only after the last digit of the previous
// text has been loaded into the output register.
// Characters leave through a single output register, one per cycle while tready is high.
// Reset: arst_n clears the controller to idle and the output register to empty.
module signed_int_to_decimal_ascii (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // value[31:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,   // character[7:0]
	output logic        m_axis_tlast    // last
);

	itoa_pkg::state_t state_q, state_d;

	logic [itoa_pkg::VALUE_W-1:0] mag_q, mag_d;
	logic [itoa_pkg::BCD_W-1:0]   bcd_q, bcd_d;
	logic                         neg_q, neg_d;
	logic [4:0]                   bit_cnt_q, bit_cnt_d;
	logic [3:0]                   dig_cnt_q, dig_cnt_d;

	logic                         out_valid_q, out_valid_d;
	logic [itoa_pkg::CHAR_W-1:0]  out_char_q, out_char_d;
	logic                         out_last_q, out_last_d;

	logic                         in_accept;
	logic                         out_free;
	logic [itoa_pkg::BCD_W-1:0]   bcd_adj;
	logic [3:0]                   top_digit;

	assign s_axis_tready = (state_q == itoa_pkg::ST_IDLE);
	assign in_accept     = s_axis_tvalid && s_axis_tready;
	assign out_free      = !out_valid_q || m_axis_tready;
	assign top_digit     = bcd_q[itoa_pkg::BCD_W-1 -: 4];

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_char_q;
	assign m_axis_tlast  = out_last_q;

	// Add-3 correction on every BCD digit before the next shift; digits are independent.
	always_comb begin
		for (int i = 0; i < itoa_pkg::NUM_DIGITS; i++) begin
			if (bcd_q[4*i +: 4] >= 4'd5) begin
				bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
			end else begin
				bcd_adj[4*i +: 4] = bcd_q[4*i +: 4];
			end
		end
	end

	always_comb begin
		state_d     = state_q;
		mag_d       = mag_q;
		bcd_d       = bcd_q;
		neg_d       = neg_q;
		bit_cnt_d   = bit_cnt_q;
		dig_cnt_d   = dig_cnt_q;
		out_valid_d = out_valid_q && !m_axis_tready;
		out_char_d  = out_char_q;
		out_last_d  = out_last_q;
		unique case (state_q)
			itoa_pkg::ST_IDLE: begin
				if (in_accept) begin
					neg_d     = s_axis_tdata[itoa_pkg::VALUE_W-1];
					// Unsigned negate keeps the most negative value exact.
					mag_d     = s_axis_tdata[itoa_pkg::VALUE_W-1] ? (~s_axis_tdata + 32'd1)
					                                              : s_axis_tdata;
					bcd_d     = '0;
					bit_cnt_d = 5'(itoa_pkg::VALUE_W - 1);
					state_d   = itoa_pkg::ST_CONV;
				end
			end
			itoa_pkg::ST_CONV: begin
				bcd_d = {bcd_adj[itoa_pkg::BCD_W-2:0], mag_q[itoa_pkg::VALUE_W-1]};
				mag_d = {mag_q[itoa_pkg::VALUE_W-2:0], 1'b0};
				if (bit_cnt_q == 5'd0) begin
					dig_cnt_d = 4'(itoa_pkg::NUM_DIGITS);
					state_d   = itoa_pkg::ST_TRIM;
				end else begin
					bit_cnt_d = bit_cnt_q - 5'd1;
				end
			end
			itoa_pkg::ST_TRIM: begin
				// Drop leading zeros but always keep the units digit.
				if (top_digit == 4'd0 && dig_cnt_q > 4'd1) begin
					bcd_d     = {bcd_q[itoa_pkg::BCD_W-5:0], 4'd0};
					dig_cnt_d = dig_cnt_q - 4'd1;
				end else if (neg_q) begin
					state_d = itoa_pkg::ST_SIGN;
				end else begin
					state_d = itoa_pkg::ST_DIGIT;
				end
			end
			itoa_pkg::ST_SIGN: begin
				if (out_free) begin
					out_valid_d = 1'b1;
					out_char_d  = itoa_pkg::CHAR_MINUS;
					out_last_d  = 1'b0;
					state_d     = itoa_pkg::ST_DIGIT;
				end
			end
			itoa_pkg::ST_DIGIT: begin
				if (out_free) begin
					out_valid_d = 1'b1;
					out_char_d  = itoa_pkg::CHAR_ZERO + {4'd0, top_digit};
					out_last_d  = (dig_cnt_q == 4'd1);
					bcd_d       = {bcd_q[itoa_pkg::BCD_W-5:0], 4'd0};
					dig_cnt_d   = dig_cnt_q - 4'd1;
					if (dig_cnt_q == 4'd1) begin
						state_d = itoa_pkg::ST_IDLE;
					end
				end
			end
			default: begin
				state_d = itoa_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= itoa_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
			bit_cnt_q   <= '0;
			dig_cnt_q   <= '0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= out_valid_d;
			bit_cnt_q   <= bit_cnt_d;
			dig_cnt_q   <= dig_cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		mag_q      <= mag_d;
		bcd_q      <= bcd_d;
		neg_q      <= neg_d;
		out_char_q <= out_char_d;
		out_last_q <= out_last_d;
	end

	// An accepted value always starts a full 32-step conversion.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> (state_q == itoa_pkg::ST_CONV) && (bit_cnt_q == 5'd31))
		else $error("conversion did not start after input request");

	// After the correction steps every digit handed to the output is a valid decimal digit.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == itoa_pkg::ST_DIGIT) |-> (top_digit <= 4'd9))
		else $error("invalid BCD digit at output");

	// The digit count stays within one to ten while characters are pending.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == itoa_pkg::ST_TRIM || state_q == itoa_pkg::ST_SIGN ||
		 state_q == itoa_pkg::ST_DIGIT) |-> (dig_cnt_q >= 4'd1 && dig_cnt_q <= 4'd10))
		else $error("digit count out of range");

	// The last character of a run is always a digit, never the sign.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tlast) |-> (m_axis_tdata != itoa_pkg::CHAR_MINUS))
		else $error("sign character flagged as last");

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the signed integer to decimal ASCII converter.
`timescale 1ns / 1ps

module tb_top;

	localparam int RADIX         = 10;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int HOLDOFF_LEN   = 400;
	localparam int SETTLE_CYCLES = 60;

	typedef struct {
		logic [itoa_pkg::VALUE_W-1:0] value;
		bit                           drain_first;
	} value_req_t;

	typedef struct {
		logic [itoa_pkg::CHAR_W-1:0] code;
		logic                        last;
	} text_char_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_axis_tvalid = 1'b0;
	logic              s_axis_tready;
	logic [31:0]       s_axis_tdata = '0;     // value[31:0]
	logic              m_axis_tvalid;
	logic              m_axis_tready = 1'b0;
	logic [7:0]        m_axis_tdata;          // character[7:0]
	logic              m_axis_tlast;          // last

	value_req_t values_pending[$];
	text_char_t expected_chars[$];
	int         mismatches = 0;
	int         values_taken = 0;
	int         values_offered = 0;
	int         cycle_count = 0;
	int         burst_left = 1;
	int         gap_left = 0;
	int         holdoff_left = 0;
	bit         holdoff_done = 1'b0;
	int         stall_mode = 0;
	int         mode_left = 0;
	int         rx_phase = 0;

	signed_int_to_decimal_ascii DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	always #4 clk = ~clk;

	// Queues the characters of one value's text, sign first, then digits from the top.
	function automatic void predict_text(input logic [itoa_pkg::VALUE_W-1:0] value);
		logic [itoa_pkg::VALUE_W-1:0] mag;
		logic [3:0]                   digit [itoa_pkg::NUM_DIGITS];
		int                           nd;
		text_char_t                   c;
		mag = value[itoa_pkg::VALUE_W-1] ? (~value + 1'b1) : value;
		nd = 0;
		do begin
			digit[nd] = 4'(mag % RADIX);
			nd++;
			mag = mag / RADIX;
		end while (mag != 0 && nd < itoa_pkg::NUM_DIGITS);
		if (value[itoa_pkg::VALUE_W-1]) begin
			c.code = itoa_pkg::CHAR_MINUS;
			c.last = 1'b0;
			expected_chars.push_back(c);
		end
		for (int k = nd - 1; k >= 0; k--) begin
			c.code = itoa_pkg::CHAR_ZERO + itoa_pkg::CHAR_W'(digit[k]);
			c.last = (k == 0);
			expected_chars.push_back(c);
		end
	endfunction

	function automatic void queue_value(input logic [itoa_pkg::VALUE_W-1:0] value,
			input bit drain_first);
		value_req_t r;
		r.value = value;
		r.drain_first = drain_first;
		values_pending.push_back(r);
	endfunction

	// Request side: a taken value is predicted at the edge where it is accepted.
	always @(posedge clk) begin
		if (arst_n && s_axis_tvalid && s_axis_tready) begin
			predict_text(s_axis_tdata);
			values_pending.delete(0);
			values_taken <= values_taken + 1;
		end
	end

	// Sender: bursts of random length with random gaps; an offered value is held until taken.
	always @(negedge clk) begin
		if (arst_n && !(s_axis_tvalid && values_offered != values_taken)) begin
			if (gap_left > 0) begin
				gap_left--;
				s_axis_tvalid <= 1'b0;
			end else if (values_pending.size() == 0 ||
					(values_pending[0].drain_first && expected_chars.size() != 0)) begin
				s_axis_tvalid <= 1'b0;
			end else begin
				s_axis_tvalid <= 1'b1;
				s_axis_tdata  <= values_pending[0].value;
				values_offered++;
				if (burst_left > 1) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(1, 12);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 50);
				end
			end
		end
	end

	// Receiver: stall patterns that change at random intervals, plus one long hold-off.
	always @(negedge clk) begin
		rx_phase++;
		if (!holdoff_done && values_taken >= 40) begin
			holdoff_left = HOLDOFF_LEN;
			holdoff_done = 1'b1;
		end
		if (holdoff_left > 0) begin
			holdoff_left--;
			m_axis_tready <= 1'b0;
		end else begin
			if (mode_left == 0) begin
				stall_mode = $urandom_range(0, 3);
				mode_left = $urandom_range(16, 80);
			end else begin
				mode_left--;
			end
			case (stall_mode)
				0: m_axis_tready <= 1'b1;
				1: m_axis_tready <= 1'($urandom_range(0, 1));
				2: m_axis_tready <= ($urandom_range(0, 3) == 0);
				default: m_axis_tready <= (rx_phase % 5 != 0);
			endcase
		end
	end

	// Checker: each character leaving the block is matched against the oldest prediction.
	always @(posedge clk) begin
		text_char_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_chars.size() == 0) begin
				$display("%0t: unexpected character %0d last %0b", $time,
					m_axis_tdata, m_axis_tlast);
				mismatches++;
			end else begin
				want = expected_chars.pop_front();
				if (m_axis_tdata !== want.code) begin
					$display("%0t: character expected %0d actual %0d", $time,
						want.code, m_axis_tdata);
					mismatches++;
				end
				if (m_axis_tlast !== want.last) begin
					$display("%0t: last expected %0b actual %0b", $time,
						want.last, m_axis_tlast);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d values and %0d characters outstanding", $time,
				values_pending.size(), expected_chars.size());
			$display("tb_top failed");
			$finish;
		end
	end

	initial begin
		longint     lo;
		longint     hi;
		longint     mag;
		longint     pow10 [11];
		int         n;
		int         kind;
		bit         neg;
		pow10[0] = 1;
		for (int i = 1; i <= 10; i++)
			pow10[i] = pow10[i-1] * 10;

		// Directed values: zero, single digits, decade edges and both ends of the range.
		queue_value(32'd0, 1'b0);
		queue_value(32'd1, 1'b0);
		queue_value(-32'sd1, 1'b0);
		queue_value(32'd9, 1'b0);
		queue_value(32'd10, 1'b0);
		queue_value(-32'sd10, 1'b0);
		queue_value(32'd99, 1'b0);
		queue_value(32'd100, 1'b0);
		queue_value(-32'sd9, 1'b0);
		queue_value(32'h7FFF_FFFF, 1'b0);
		queue_value(32'h8000_0000, 1'b0);
		queue_value(32'h8000_0001, 1'b0);
		queue_value(32'd1000000000, 1'b0);
		queue_value(32'd999999999, 1'b0);
		queue_value(-32'sd999999999, 1'b0);
		queue_value(-32'sd1000000000, 1'b0);
		queue_value(32'h5555_5555, 1'b0);
		queue_value(32'hAAAA_AAAA, 1'b0);
		queue_value(32'd1234567890, 1'b0);
		queue_value(32'd4000000000, 1'b0);

		for (int i = 0; i < 330; i++) begin
			kind = $urandom_range(0, 3);
			neg = $urandom_range(0, 1);
			if (kind == 0) begin
				mag = $urandom;
				queue_value(32'(mag), (i == 0) || (i == 180));
			end else if (kind == 3) begin
				mag = $urandom_range(0, 20);
				queue_value(neg ? 32'(-mag) : 32'(mag), (i == 0) || (i == 180));
			end else begin
				// Pick a digit count first so that short and long texts are equally common.
				n = $urandom_range(1, 10);
				lo = (n == 1) ? 0 : pow10[n-1];
				hi = (n == 10) ? (neg ? 64'd2147483648 : 64'd2147483647) : pow10[n] - 1;
				mag = $urandom_range(32'(hi), 32'(lo));
				queue_value(neg ? 32'(-mag) : 32'(mag), (i == 0) || (i == 180));
			end
		end

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (values_pending.size() != 0 || expected_chars.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (mismatches == 0) begin
			$display("tb_top passed");
		end else begin
			$display("tb_top failed");
		end
		$finish;
	end

endmodule

// ===== signed_int_to_decimal_ascii.f =====
rtl/itoa_pkg.sv
rtl/signed_int_to_decimal_ascii.sv
tb/sv/tb_top.sv
